### sv/fr90_pkg.sv
// Shared types and constants of the 90-degree frame rotator.
package fr90_pkg;

  // Pixel and configuration widths.
  localparam int PIX_W     = 24;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_DIR     = 2'd2;

  // Configuration reset values.
  localparam logic [CFG_W-1:0] WIDTH_RESET  = 7'd64;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 7'd64;
  localparam logic             DIR_RESET    = 1'b0;

  // Input item kinds.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Turn directions.
  localparam logic DIR_CW  = 1'b0;
  localparam logic DIR_CCW = 1'b1;

  // Depth of the command queue between front and back end.
  localparam int CMDQ_DEPTH = 4;

  // Control part of one command handed from the front end to the back end.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic row_end;
    logic frame_end;
  } cmd_ctrl_t;

endpackage

### sv/frame_rotate_90.sv
// Top level of the 90-degree frame rotator with ping-pong frame banks.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata: pixel_in[23:0]; tuser: opcode (0 load, 1 drain)
//   m_axis    out        tdata: pixel_out[23:0]; tuser: row_end; tlast: frame_end
//   cfg       in         index 0 image_width, 1 image_height, 2 turn_direction
//
// The block sustains one item per cycle while the output side takes its
// results; the back end spends at most one memory write and one memory read
// per item, both in the same cycle on the two banks. An accepted load or
// read is written into the command queue; its read then fills the result
// register, which presents the result. The front end stalls only when the
// four-entry command queue is full, and the back end stalls only while its
// result register is held by the output side. Reset clears counters, the
// pending flag and the queue; the frame memory needs no clearing pass.
module frame_rotate_90 #(
  parameter int MAX_DIM = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port.
  input  logic                           cfg_we_i,
  input  logic [fr90_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [fr90_pkg::CFG_W-1:0]     cfg_data_i,
  // Input stream.
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [23:0]                    s_axis_tdata_i,  // [23:0] pixel_in
  input  logic                           s_axis_tuser_i,  // [0] opcode
  // Output stream.
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [23:0]                    m_axis_tdata_o,  // [23:0] pixel_out
  output logic                           m_axis_tuser_o,  // [0] row_end
  output logic                           m_axis_tlast_o   // frame_end
);

  // Memory address is {bank, row, column}.
  localparam int CW    = $clog2(MAX_DIM);
  localparam int AW    = 2 * CW + 1;
  localparam int CTL_W = $bits(fr90_pkg::cmd_ctrl_t);
  localparam int QW    = CTL_W + 2 * AW + fr90_pkg::PIX_W;

  logic                       push, q_full, q_valid, q_pop;
  fr90_pkg::cmd_ctrl_t        push_ctrl, q_ctrl;
  logic [AW-1:0]              push_waddr, push_raddr, q_waddr, q_raddr;
  logic [fr90_pkg::PIX_W-1:0] push_wdata, q_wdata;
  logic [QW-1:0]              push_entry, q_entry;

  // The front end updates all frame counters at acceptance and turns each load,
  // or item accepted with a frame pending, into one command: a write to the load
  // bank for a load and a read of a pending frame, with row and frame marks.
  fr90_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_opcode_i (s_axis_tuser_i),
    .in_pixel_i  (s_axis_tdata_i),
    .q_full_i    (q_full),
    .cmd_push_o  (push),
    .cmd_ctrl_o  (push_ctrl),
    .cmd_waddr_o (push_waddr),
    .cmd_raddr_o (push_raddr),
    .cmd_wdata_o (push_wdata)
  );

  assign push_entry = {push_ctrl, push_waddr, push_raddr, push_wdata};

  fr90_cmd_queue #(
    .WIDTH (QW),
    .DEPTH (fr90_pkg::CMDQ_DEPTH)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_entry)
  );

  assign {q_ctrl, q_waddr, q_raddr, q_wdata} = q_entry;

  // The back end executes commands in order against the frame memory.
  fr90_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_ctrl_i        (q_ctrl),
    .q_waddr_i       (q_waddr),
    .q_raddr_i       (q_raddr),
    .q_wdata_i       (q_wdata),
    .q_pop_o         (q_pop),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .out_pixel_o     (m_axis_tdata_o),
    .out_row_end_o   (m_axis_tuser_o),
    .out_frame_end_o (m_axis_tlast_o)
  );

  // The last pixel of a frame is always also the last pixel of its row.
  a_frame_end_is_row_end : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> m_axis_tuser_o
  ) else $error("frame end without row end");

  // A read never overwrites a result that the output side has not taken.
  a_no_result_overrun : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (q_pop && q_ctrl.rd_en) |-> (!m_axis_tvalid_o || m_axis_tready_i)
  ) else $error("result register overwritten");

  // A new result only follows a read command taken from the queue.
  a_result_from_read : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(q_pop && q_ctrl.rd_en)
  ) else $error("result without read command");

endmodule

### sv/fr90_front.sv
// Front end: configuration, load and emit counters, command generation.
module fr90_front #(
  parameter int MAX_DIM = 64,
  localparam int CW = $clog2(MAX_DIM),
  localparam int AW = 2 * CW + 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fr90_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [fr90_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                in_opcode_i,
  input  logic [fr90_pkg::PIX_W-1:0]          in_pixel_i,
  input  logic                                q_full_i,
  output logic                                cmd_push_o,
  output fr90_pkg::cmd_ctrl_t                 cmd_ctrl_o,
  output logic [AW-1:0]                       cmd_waddr_o,
  output logic [AW-1:0]                       cmd_raddr_o,
  output logic [fr90_pkg::PIX_W-1:0]          cmd_wdata_o
);

  localparam int DW   = $clog2(MAX_DIM + 1);
  localparam int CMPW = (DW > fr90_pkg::CFG_W) ? DW : fr90_pkg::CFG_W;

  logic [fr90_pkg::CFG_W-1:0] cfg_width_q, cfg_height_q;
  logic                       cfg_dir_q;

  logic [CW-1:0] lcol_q, lcol_d, lrow_q, lrow_d;
  logic [CW-1:0] ecol_q, ecol_d, erow_q, erow_d;
  logic          bank_q, bank_d;
  logic          pend_q, pend_d;
  logic [DW-1:0] pend_w_q, pend_w_d, pend_h_q, pend_h_d;
  logic          pend_dir_q, pend_dir_d;

  logic [CMPW-1:0] w_ext, h_ext, w_lim, h_lim;
  logic [DW-1:0]   img_w, img_h;
  logic [DW-1:0]   x_full, y_full;
  logic            rend, fend, accept, is_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= fr90_pkg::WIDTH_RESET;
      cfg_height_q <= fr90_pkg::HEIGHT_RESET;
      cfg_dir_q    <= fr90_pkg::DIR_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        fr90_pkg::CFG_IMAGE_WIDTH:  cfg_width_q  <= cfg_data_i;
        fr90_pkg::CFG_IMAGE_HEIGHT: cfg_height_q <= cfg_data_i;
        fr90_pkg::CFG_TURN_DIR:     cfg_dir_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // A dimension of zero acts as one, any value above the maximum acts as the maximum.
  always_comb begin
    w_ext = CMPW'(cfg_width_q);
    h_ext = CMPW'(cfg_height_q);
    if (w_ext == '0)                  w_lim = CMPW'(1);
    else if (w_ext > CMPW'(MAX_DIM))  w_lim = CMPW'(MAX_DIM);
    else                              w_lim = w_ext;
    if (h_ext == '0)                  h_lim = CMPW'(1);
    else if (h_ext > CMPW'(MAX_DIM))  h_lim = CMPW'(MAX_DIM);
    else                              h_lim = h_ext;
    img_w = w_lim[DW-1:0];
    img_h = h_lim[DW-1:0];
  end

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_load    = (in_opcode_i == fr90_pkg::OP_LOAD);

  // Source coordinates of the next rotated pixel.
  always_comb begin
    if (pend_dir_q == fr90_pkg::DIR_CW) begin
      x_full = pend_w_q - DW'(1) - DW'(erow_q);
      y_full = DW'(ecol_q);
    end else begin
      x_full = DW'(erow_q);
      y_full = pend_h_q - DW'(1) - DW'(ecol_q);
    end
    rend = (DW'(ecol_q) + DW'(1)) >= pend_h_q;
    fend = rend && ((DW'(erow_q) + DW'(1)) >= pend_w_q);
  end

  always_comb begin
    lcol_d     = lcol_q;
    lrow_d     = lrow_q;
    ecol_d     = ecol_q;
    erow_d     = erow_q;
    bank_d     = bank_q;
    pend_d     = pend_q;
    pend_w_d   = pend_w_q;
    pend_h_d   = pend_h_q;
    pend_dir_d = pend_dir_q;
    if (accept) begin
      if (pend_q) begin
        if (rend) begin
          ecol_d = '0;
          if (fend) begin
            erow_d = '0;
            pend_d = 1'b0;
          end else begin
            erow_d = erow_q + CW'(1);
          end
        end else begin
          ecol_d = ecol_q + CW'(1);
        end
      end
      if (is_load) begin
        if ((DW'(lcol_q) + DW'(1)) >= img_w) begin
          lcol_d = '0;
          if ((DW'(lrow_q) + DW'(1)) >= img_h) begin
            // Frame complete: swap banks, the new frame starts emitting.
            lrow_d     = '0;
            bank_d     = !bank_q;
            pend_d     = 1'b1;
            ecol_d     = '0;
            erow_d     = '0;
            pend_w_d   = img_w;
            pend_h_d   = img_h;
            pend_dir_d = cfg_dir_q;
          end else begin
            lrow_d = lrow_q + CW'(1);
          end
        end else begin
          lcol_d = lcol_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcol_q     <= '0;
      lrow_q     <= '0;
      ecol_q     <= '0;
      erow_q     <= '0;
      bank_q     <= 1'b0;
      pend_q     <= 1'b0;
      pend_w_q   <= '0;
      pend_h_q   <= '0;
      pend_dir_q <= 1'b0;
    end else begin
      lcol_q     <= lcol_d;
      lrow_q     <= lrow_d;
      ecol_q     <= ecol_d;
      erow_q     <= erow_d;
      bank_q     <= bank_d;
      pend_q     <= pend_d;
      pend_w_q   <= pend_w_d;
      pend_h_q   <= pend_h_d;
      pend_dir_q <= pend_dir_d;
    end
  end

  always_comb begin
    cmd_ctrl_o.wr_en     = is_load;
    cmd_ctrl_o.rd_en     = pend_q;
    cmd_ctrl_o.row_end   = rend;
    cmd_ctrl_o.frame_end = fend;
  end

  assign cmd_push_o  = accept && (is_load || pend_q);
  assign cmd_waddr_o = {bank_q, lrow_q, lcol_q};
  assign cmd_raddr_o = {!bank_q, y_full[CW-1:0], x_full[CW-1:0]};
  assign cmd_wdata_o = in_pixel_i;

endmodule

### sv/fr90_cmd_queue.sv
// Small first-in first-out queue of commands between front and back end.
module fr90_cmd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [NW-1:0]    count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == NW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign rdata_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      if (do_push && !do_pop)      count_q <= count_q + NW'(1);
      else if (!do_push && do_pop) count_q <= count_q - NW'(1);
    end
  end

endmodule

### sv/fr90_back.sv
// Back end: ping-pong frame memory and the registered result stage.
module fr90_back #(
  parameter int MAX_DIM = 64,
  localparam int CW = $clog2(MAX_DIM),
  localparam int AW = 2 * CW + 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  fr90_pkg::cmd_ctrl_t         q_ctrl_i,
  input  logic [AW-1:0]               q_waddr_i,
  input  logic [AW-1:0]               q_raddr_i,
  input  logic [fr90_pkg::PIX_W-1:0]  q_wdata_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [fr90_pkg::PIX_W-1:0]  out_pixel_o,
  output logic                        out_row_end_o,
  output logic                        out_frame_end_o
);

  localparam int DEPTH = 2 ** AW;

  logic [fr90_pkg::PIX_W-1:0] mem [DEPTH];
  logic [fr90_pkg::PIX_W-1:0] rd_data_q;
  logic                       rd_rend_q, rd_fend_q;
  logic                       rd_vld_q, rd_vld_d;
  logic                       do_read;

  // A read may only issue when the result register is free or drains now.
  assign q_pop_o = q_valid_i && (!q_ctrl_i.rd_en || !rd_vld_q || out_ready_i);
  assign do_read = q_pop_o && q_ctrl_i.rd_en;

  // Write and read go to opposite banks, so their order does not matter.
  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_ctrl_i.wr_en) mem[q_waddr_i] <= q_wdata_i;
    if (do_read) begin
      rd_data_q <= mem[q_raddr_i];
      rd_rend_q <= q_ctrl_i.row_end;
      rd_fend_q <= q_ctrl_i.frame_end;
    end
  end

  always_comb begin
    rd_vld_d = rd_vld_q;
    if (do_read)          rd_vld_d = 1'b1;
    else if (out_ready_i) rd_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rd_vld_q <= 1'b0;
    else         rd_vld_q <= rd_vld_d;
  end

  assign out_valid_o     = rd_vld_q;
  assign out_pixel_o     = rd_data_q;
  assign out_row_end_o   = rd_rend_q;
  assign out_frame_end_o = rd_fend_q;

endmodule

### verif/frame_rotate_90_tb.sv
// Self-checking testbench for the 90-degree frame rotator with ping-pong banks.
module frame_rotate_90_tb;

  localparam int DIM  = 64;
  localparam int BANK = DIM * DIM;

  // One source item as it travels on the input stream.
  typedef struct packed {
    logic          op;
    logic [23:0]   pix;
  } src_item_t;

  // One rotated pixel as it travels on the output stream.
  typedef struct packed {
    logic [23:0]   pixel;
    logic          row_end;
    logic          frame_end;
  } rot_pixel_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Configuration port, driven only from the stimulus process.
  logic                           cfg_we    = 1'b0;
  logic [fr90_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [fr90_pkg::CFG_W-1:0]     cfg_data  = '0;

  // Input stream, driven by the pixel driver.
  logic        s_tvalid = 1'b0;
  logic [23:0] s_tdata  = '0;
  logic        s_tuser  = fr90_pkg::OP_LOAD;
  logic        s_tready;

  // Output stream, paced by the sink.
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  frame_rotate_90 dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  always #5 clk = ~clk;

  // Pixels waiting to be offered, and rotated pixels the block still owes us.
  src_item_t  pixel_feed[$];
  rot_pixel_t rotated_due[$];

  int fails      = 0;
  int items_made = 0;
  bit quiet      = 1'b0;   // no idling on either side once set

  // Long output hold-offs: the stimulus asks for one, the sink serves it.
  int holds_asked  = 0;
  int holds_served = 0;

  // ---------------------------------------------------------------------------
  // Rotation predictor: its own copy of the registers, banks and counters.
  // ---------------------------------------------------------------------------
  logic [6:0]  cfg_width  = fr90_pkg::WIDTH_RESET;
  logic [6:0]  cfg_height = fr90_pkg::HEIGHT_RESET;
  logic        cfg_dir    = fr90_pkg::DIR_RESET;

  logic [23:0] bank_pix     [2][BANK];
  bit          bank_written [2][BANK];
  logic [5:0]  load_col      = '0;
  logic [5:0]  load_row      = '0;
  logic [5:0]  emit_col      = '0;
  logic [5:0]  emit_row      = '0;
  logic        load_bank     = 1'b0;
  logic        frame_pending = 1'b0;
  logic [6:0]  pend_w        = '0;
  logic [6:0]  pend_h        = '0;
  logic        pend_dir      = fr90_pkg::DIR_CW;

  // A dimension of zero counts as one; anything above DIM saturates to DIM.
  function automatic logic [6:0] dim_limit(input logic [6:0] v);
    if (v == 7'd0) return 7'd1;
    if (v > 7'(DIM)) return 7'(DIM);
    return v;
  endfunction

  // Advances the predictor by one accepted item and queues the pixel it emits.
  function automatic void rotate_step(input logic op, input logic [23:0] pix);
    logic [6:0] x;
    logic [6:0] y;
    logic [6:0] w;
    logic [6:0] h;
    logic       rend;
    logic       fend;
    rot_pixel_t res;
    // The emission reads the pending bank before the load of the same item.
    if (frame_pending) begin
      if (pend_dir == fr90_pkg::DIR_CW) begin
        x = pend_w - 7'd1 - {1'b0, emit_row};
        y = {1'b0, emit_col};
      end else begin
        x = {1'b0, emit_row};
        y = pend_h - 7'd1 - {1'b0, emit_col};
      end
      rend = ({1'b0, emit_col} + 7'd1 >= pend_h);
      fend = rend && ({1'b0, emit_row} + 7'd1 >= pend_w);
      res.pixel     = bank_pix[load_bank ^ 1'b1][{y[5:0], x[5:0]}];
      res.row_end   = rend;
      res.frame_end = fend;
      rotated_due.push_back(res);
      if (rend) begin
        emit_col = '0;
        if (fend) begin
          emit_row      = '0;
          frame_pending = 1'b0;
        end else begin
          emit_row = emit_row + 6'd1;
        end
      end else begin
        emit_col = emit_col + 6'd1;
      end
    end
    if (op == fr90_pkg::OP_LOAD) begin
      // Current register values apply at every load, even in mid-frame.
      w = dim_limit(cfg_width);
      h = dim_limit(cfg_height);
      bank_pix[load_bank][{load_row, load_col}]     = pix;
      bank_written[load_bank][{load_row, load_col}] = 1'b1;
      if ({1'b0, load_col} + 7'd1 >= w) begin
        load_col = '0;
        if ({1'b0, load_row} + 7'd1 >= h) begin
          // Frame complete: it replaces whatever was still being emitted.
          load_row      = '0;
          load_bank     = load_bank ^ 1'b1;
          frame_pending = 1'b1;
          emit_col      = '0;
          emit_row      = '0;
          pend_w        = w;
          pend_h        = h;
          pend_dir      = cfg_dir;
        end else begin
          load_row = load_row + 6'd1;
        end
      end else begin
        load_col = load_col + 6'd1;
      end
    end
  endfunction

  // A resize in the middle of a frame is allowed only when every pixel the
  // resized frame will be read from is sure to hold data: the positions
  // already passed in this frame must have been written at some point.
  function automatic bit dims_safe(input logic [6:0] w_raw, input logic [6:0] h_raw);
    int w;
    int h;
    w = dim_limit(w_raw);
    h = dim_limit(h_raw);
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++)
        if ((y < load_row || (y == load_row && x < load_col)) &&
            !bank_written[load_bank][y * DIM + x])
          return 1'b0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: checks results and feeds accepted items to the predictor.
  // ---------------------------------------------------------------------------
  logic src_taken = 1'b0;   // the offered item was accepted at the last edge

  always @(posedge clk) begin : stream_check
    rot_pixel_t want;
    // Check the output first: a result never belongs to an item accepted at
    // the same edge.
    if (rst_n && m_tvalid && m_tready) begin
      if (rotated_due.size() == 0) begin
        $error("pixel_out %h arrived with nothing expected", m_tdata);
        fails++;
      end else begin
        want = rotated_due.pop_front();
        if (m_tdata !== want.pixel) begin
          $error("pixel_out mismatch: expected %h, got %h", want.pixel, m_tdata);
          fails++;
        end
        if (m_tuser !== want.row_end) begin
          $error("row_end mismatch: expected %b, got %b", want.row_end, m_tuser);
          fails++;
        end
        if (m_tlast !== want.frame_end) begin
          $error("frame_end mismatch: expected %b, got %b", want.frame_end, m_tlast);
          fails++;
        end
      end
    end
    if (rst_n && s_tvalid && s_tready) rotate_step(s_tuser, s_tdata);
    src_taken <= rst_n && s_tvalid && s_tready;
  end

  // ---------------------------------------------------------------------------
  // Driver: offers queued pixels, with random gaps between them.
  // ---------------------------------------------------------------------------
  int src_gap = 0;

  always @(negedge clk) begin : pixel_driver
    src_item_t next_item;
    if (!rst_n) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || src_taken) begin
      if (src_gap != 0) begin
        src_gap  <= src_gap - 1;
        s_tvalid <= 1'b0;
      end else if (!quiet && pixel_feed.size() != 0 && $urandom_range(0, 7) == 0) begin
        src_gap  <= $urandom_range(0, 5);
        s_tvalid <= 1'b0;
      end else if (pixel_feed.size() != 0) begin
        next_item = pixel_feed.pop_front();
        s_tvalid  <= 1'b1;
        s_tdata   <= next_item.pix;
        s_tuser   <= next_item.op;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sink: random stalls, plus a long hold-off on request that lets the
  // block fill up and push back on its input.
  // ---------------------------------------------------------------------------
  int sink_gap  = 0;
  int hold_left = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (holds_served < holds_asked && m_tvalid) begin
      hold_left    <= 63;
      holds_served <= holds_served + 1;
      m_tready     <= 1'b0;
    end else if (sink_gap != 0) begin
      sink_gap <= sink_gap - 1;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      sink_gap <= $urandom_range(0, 5);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic push_item(input logic op, input logic [23:0] pix);
    src_item_t it;
    it.op  = op;
    it.pix = pix;
    pixel_feed.push_back(it);
    items_made++;
  endtask

  // Registers are only written while the block is idle, so the mirror can be
  // updated right away.
  task automatic set_reg(input logic [fr90_pkg::CFG_IDX_W-1:0] idx,
                         input logic [fr90_pkg::CFG_W-1:0]     val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      fr90_pkg::CFG_IMAGE_WIDTH:  cfg_width  = val;
      fr90_pkg::CFG_IMAGE_HEIGHT: cfg_height = val;
      fr90_pkg::CFG_TURN_DIR:     cfg_dir    = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every item is taken and every result has come, then gives
  // items without a result time to leave the command queue and the back end.
  task automatic wait_idle();
    do @(posedge clk);
    while (pixel_feed.size() != 0 || s_tvalid || rotated_due.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus: directed phases, then random ones, then a quiet tail.
  // ---------------------------------------------------------------------------
  logic [6:0] extremes [5] = '{7'd0, 7'd1, 7'd64, 7'd65, 7'd127};

  initial begin : stimulus
    logic [6:0] new_w;
    logic [6:0] new_h;
    int         fsize;
    int         frames;
    int         extra;
    int         n;
    int         phase_no;
    bit         pressure;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drains with nothing pending give no result. Then a 2x2 frame is
    // rotated clockwise with the direction left at its reset value.
    set_reg(fr90_pkg::CFG_IMAGE_WIDTH, 7'd2);
    set_reg(fr90_pkg::CFG_IMAGE_HEIGHT, 7'd2);
    push_item(fr90_pkg::OP_DRAIN, 24'h000000);
    push_item(fr90_pkg::OP_DRAIN, 24'hFFFFFF);
    push_item(fr90_pkg::OP_LOAD, 24'hFFFFFF);
    push_item(fr90_pkg::OP_LOAD, 24'h000000);
    push_item(fr90_pkg::OP_LOAD, 24'h123456);
    push_item(fr90_pkg::OP_LOAD, 24'hEDCBA9);
    repeat (5) push_item(fr90_pkg::OP_DRAIN, 24'h5A5A5A);
    wait_idle();

    // Zero width acts as one; counterclockwise; a second frame loads while
    // the first is emitted.
    set_reg(fr90_pkg::CFG_IMAGE_WIDTH, 7'd0);
    set_reg(fr90_pkg::CFG_IMAGE_HEIGHT, 7'd3);
    set_reg(fr90_pkg::CFG_TURN_DIR, 7'(fr90_pkg::DIR_CCW));
    push_item(fr90_pkg::OP_LOAD, 24'hAAAAAA);
    push_item(fr90_pkg::OP_LOAD, 24'h555555);
    push_item(fr90_pkg::OP_LOAD, 24'h800001);
    push_item(fr90_pkg::OP_LOAD, 24'h7FFFFE);
    push_item(fr90_pkg::OP_LOAD, 24'h0F0F0F);
    push_item(fr90_pkg::OP_LOAD, 24'hF0F0F0);
    push_item(fr90_pkg::OP_DRAIN, 24'h000000);
    push_item(fr90_pkg::OP_DRAIN, 24'hFFFFFF);
    wait_idle();

    // Stop three pixels into a 2x2 frame and shrink it to 1x1 mid-load.
    set_reg(fr90_pkg::CFG_IMAGE_WIDTH, 7'd2);
    set_reg(fr90_pkg::CFG_IMAGE_HEIGHT, 7'd2);
    set_reg(fr90_pkg::CFG_TURN_DIR, 7'(fr90_pkg::DIR_CW));
    push_item(fr90_pkg::OP_LOAD, 24'h010203);
    push_item(fr90_pkg::OP_LOAD, 24'h040506);
    push_item(fr90_pkg::OP_LOAD, 24'h070809);
    wait_idle();
    if (dims_safe(7'd1, 7'd1)) begin
      set_reg(fr90_pkg::CFG_IMAGE_WIDTH, 7'd1);
      set_reg(fr90_pkg::CFG_IMAGE_HEIGHT, 7'd1);
    end
    push_item(fr90_pkg::OP_LOAD, 24'hC0FFEE);
    push_item(fr90_pkg::OP_DRAIN, 24'h000000);
    wait_idle();

    // A 2x1 frame stays pending; a 1x1 frame then completes after one
    // emitted pixel and cuts the older frame short.
    set_reg(fr90_pkg::CFG_IMAGE_WIDTH, 7'd2);
    push_item(fr90_pkg::OP_LOAD, 24'h111111);
    push_item(fr90_pkg::OP_LOAD, 24'h222222);
    wait_idle();
    set_reg(fr90_pkg::CFG_IMAGE_WIDTH, 7'd1);
    push_item(fr90_pkg::OP_LOAD, 24'h333333);
    push_item(fr90_pkg::OP_DRAIN, 24'h444444);

    // Random phases. Each one starts from an idle block, may resize (also in
    // mid-frame when that is safe) and loads mostly whole frames.
    phase_no = 0;
    while (items_made < 1290) begin
      wait_idle();
      phase_no++;
      pressure = (phase_no == 3 || phase_no == 12);
      if (pressure) begin
        new_w = 7'd8;
        new_h = 7'd8;
      end else begin
        case ($urandom_range(0, 9))
          0: begin
            new_w = extremes[$urandom_range(0, 4)];
            new_h = 7'($urandom_range(1, 3));
          end
          1: begin
            new_h = extremes[$urandom_range(0, 4)];
            new_w = 7'($urandom_range(1, 3));
          end
          default: begin
            new_w = 7'($urandom_range(1, 8));
            new_h = 7'($urandom_range(1, 8));
          end
        endcase
      end
      if (($urandom_range(0, 2) != 0 || pressure) && dims_safe(new_w, new_h)) begin
        set_reg(fr90_pkg::CFG_IMAGE_WIDTH, new_w);
        set_reg(fr90_pkg::CFG_IMAGE_HEIGHT, new_h);
      end
      if ($urandom_range(0, 1) == 1)
        set_reg(fr90_pkg::CFG_TURN_DIR, 7'($urandom_range(0, 1)));
      fsize = int'(dim_limit(cfg_width)) * int'(dim_limit(cfg_height));
      if (pressure) begin
        // The sink holds off while a long run is offered.
        holds_asked++;
        n = 128;
      end else if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 20);
        repeat (n) push_item(fr90_pkg::OP_DRAIN, 24'($urandom()));
        continue;
      end else begin
        frames = (fsize > 32) ? 1 : $urandom_range(1, 3);
        extra  = $urandom_range(0, (fsize > 16) ? 4 : fsize - 1);
        n      = frames * fsize + extra;
      end
      repeat (n)
        push_item(($urandom_range(0, 7) == 0) ? fr90_pkg::OP_DRAIN : fr90_pkg::OP_LOAD,
                  24'($urandom()));
    end

    // Quiet tail: two 3x4 frames and a full drain with no idling.
    wait_idle();
    quiet = 1'b1;
    if (dims_safe(7'd3, 7'd4)) begin
      set_reg(fr90_pkg::CFG_IMAGE_WIDTH, 7'd3);
      set_reg(fr90_pkg::CFG_IMAGE_HEIGHT, 7'd4);
    end
    fsize = int'(dim_limit(cfg_width)) * int'(dim_limit(cfg_height));
    repeat (2 * fsize) push_item(fr90_pkg::OP_LOAD, 24'($urandom()));
    repeat (fsize) push_item(fr90_pkg::OP_DRAIN, 24'($urandom()));

    wait_idle();
    repeat (10) @(posedge clk);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### filelist.f
sv/fr90_pkg.sv
sv/fr90_front.sv
sv/fr90_cmd_queue.sv
sv/fr90_back.sv
sv/frame_rotate_90.sv
verif/frame_rotate_90_tb.sv
